// ===== rtl/core/modexp_pkg.sv =====
// Constants, microcode word type and control program for the modular exponentiation core.
package modexp_pkg;

    localparam int BASE_W   = 30;
    localparam int EXP_W    = 63;
    localparam int EXP_LO_W = 59;
    localparam int PROD_W   = 62;
    localparam int UPC_W    = 4;

    localparam logic [BASE_W-1:0] MODULUS = 30'd1000000007;
    localparam logic [BASE_W-1:0] EXP_MOD = MODULUS - 30'd1;

    // Barrett constants floor(2^60 / m) for p and p-1; each fits in 31 bits
    localparam logic [BASE_W:0] BARRETT_MU = 31'((64'd1 << 60) / 64'(MODULUS));
    localparam logic [BASE_W:0] EXP_MU     = 31'((64'd1 << 60) / 64'(EXP_MOD));

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_MULAB,
        OP_MULMU,
        OP_MULP,
        OP_FIX,
        OP_OUT
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_E_ZERO,
        C_E_EVEN,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic             src_sq;   // multiply sq * sq instead of acc * sq
        logic             dest_sq;  // reduced product goes to sq instead of acc
        logic             shift_e;  // shift exponent right after the write
        logic             mod_e;    // reduce modulo p-1 into the exponent register
        logic [UPC_W-1:0] target;
    } ucode_t;

    localparam logic [UPC_W-1:0] A_OUT  = 4'd0;
    localparam logic [UPC_W-1:0] A_IDLE = 4'd1;
    localparam logic [UPC_W-1:0] A_TEST = 4'd5;
    localparam logic [UPC_W-1:0] A_BIT  = 4'd6;
    localparam logic [UPC_W-1:0] A_MUL  = 4'd7;
    localparam logic [UPC_W-1:0] A_SQR  = 4'd11;

    // (hi * 2^59) mod (p-1) for the top exponent bits; keeps the folded exponent below 2^60
    function automatic logic [BASE_W-1:0] exp_fold(input logic [EXP_W-EXP_LO_W-1:0] hi);
        logic [BASE_W-1:0] r;
        unique case (hi)
            4'd0:  r = '0;
            4'd1:  r = BASE_W'((64'd1 << EXP_LO_W) % 64'(EXP_MOD));
            4'd2:  r = BASE_W'((64'd2 << EXP_LO_W) % 64'(EXP_MOD));
            4'd3:  r = BASE_W'((64'd3 << EXP_LO_W) % 64'(EXP_MOD));
            4'd4:  r = BASE_W'((64'd4 << EXP_LO_W) % 64'(EXP_MOD));
            4'd5:  r = BASE_W'((64'd5 << EXP_LO_W) % 64'(EXP_MOD));
            4'd6:  r = BASE_W'((64'd6 << EXP_LO_W) % 64'(EXP_MOD));
            4'd7:  r = BASE_W'((64'd7 << EXP_LO_W) % 64'(EXP_MOD));
            4'd8:  r = BASE_W'((64'd8 << EXP_LO_W) % 64'(EXP_MOD));
            4'd9:  r = BASE_W'((64'd9 << EXP_LO_W) % 64'(EXP_MOD));
            4'd10: r = BASE_W'((64'd10 << EXP_LO_W) % 64'(EXP_MOD));
            4'd11: r = BASE_W'((64'd11 << EXP_LO_W) % 64'(EXP_MOD));
            4'd12: r = BASE_W'((64'd12 << EXP_LO_W) % 64'(EXP_MOD));
            4'd13: r = BASE_W'((64'd13 << EXP_LO_W) % 64'(EXP_MOD));
            4'd14: r = BASE_W'((64'd14 << EXP_LO_W) % 64'(EXP_MOD));
            4'd15: r = BASE_W'((64'd15 << EXP_LO_W) % 64'(EXP_MOD));
        endcase
        return r;
    endfunction

    function automatic ucode_t ucode(input logic [UPC_W-1:0] addr);
        ucode_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, src_sq: 1'b0, dest_sq: 1'b0,
              shift_e: 1'b0, mod_e: 1'b0, target: A_IDLE};
        unique case (addr)
            4'd0:  w = '{op: OP_OUT,   cond: C_OUT_BUSY, src_sq: 1'b0, dest_sq: 1'b0,
                         shift_e: 1'b0, mod_e: 1'b0, target: A_OUT};
            4'd1:  w = '{op: OP_LOAD,  cond: C_NO_START, src_sq: 1'b0, dest_sq: 1'b0,
                         shift_e: 1'b0, mod_e: 1'b0, target: A_IDLE};
            // folded exponent mod (p-1) by Barrett
            4'd2:  w = '{op: OP_MULMU, cond: C_NEVER,    src_sq: 1'b0, dest_sq: 1'b0,
                         shift_e: 1'b0, mod_e: 1'b1, target: A_IDLE};
            4'd3:  w = '{op: OP_MULP,  cond: C_NEVER,    src_sq: 1'b0, dest_sq: 1'b0,
                         shift_e: 1'b0, mod_e: 1'b1, target: A_IDLE};
            4'd4:  w = '{op: OP_FIX,   cond: C_NEVER,    src_sq: 1'b0, dest_sq: 1'b0,
                         shift_e: 1'b0, mod_e: 1'b1, target: A_IDLE};
            4'd5:  w = '{op: OP_NOP,   cond: C_E_ZERO,   src_sq: 1'b0, dest_sq: 1'b0,
                         shift_e: 1'b0, mod_e: 1'b0, target: A_OUT};
            4'd6:  w = '{op: OP_NOP,   cond: C_E_EVEN,   src_sq: 1'b0, dest_sq: 1'b0,
                         shift_e: 1'b0, mod_e: 1'b0, target: A_SQR};
            // acc = acc * sq mod p
            4'd7:  w = '{op: OP_MULAB, cond: C_NEVER,    src_sq: 1'b0, dest_sq: 1'b0,
                         shift_e: 1'b0, mod_e: 1'b0, target: A_IDLE};
            4'd8:  w = '{op: OP_MULMU, cond: C_NEVER,    src_sq: 1'b0, dest_sq: 1'b0,
                         shift_e: 1'b0, mod_e: 1'b0, target: A_IDLE};
            4'd9:  w = '{op: OP_MULP,  cond: C_NEVER,    src_sq: 1'b0, dest_sq: 1'b0,
                         shift_e: 1'b0, mod_e: 1'b0, target: A_IDLE};
            4'd10: w = '{op: OP_FIX,   cond: C_NEVER,    src_sq: 1'b0, dest_sq: 1'b0,
                         shift_e: 1'b0, mod_e: 1'b0, target: A_IDLE};
            // sq = sq * sq mod p, then next exponent bit
            4'd11: w = '{op: OP_MULAB, cond: C_NEVER,    src_sq: 1'b1, dest_sq: 1'b1,
                         shift_e: 1'b0, mod_e: 1'b0, target: A_IDLE};
            4'd12: w = '{op: OP_MULMU, cond: C_NEVER,    src_sq: 1'b1, dest_sq: 1'b1,
                         shift_e: 1'b0, mod_e: 1'b0, target: A_IDLE};
            4'd13: w = '{op: OP_MULP,  cond: C_NEVER,    src_sq: 1'b1, dest_sq: 1'b1,
                         shift_e: 1'b0, mod_e: 1'b0, target: A_IDLE};
            4'd14: w = '{op: OP_FIX,   cond: C_ALWAYS,   src_sq: 1'b1, dest_sq: 1'b1,
                         shift_e: 1'b1, mod_e: 1'b0, target: A_TEST};
            default: w = '{op: OP_NOP, cond: C_ALWAYS,   src_sq: 1'b0, dest_sq: 1'b0,
                           shift_e: 1'b0, mod_e: 1'b0, target: A_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/modular_exponentiation.sv =====
// Microcoded square-and-multiply core: base ^ (exponent mod p-1) mod p, p = 1000000007.
// A new word is accepted only while idle; the next is taken once the result is registered.
// The reduced exponent is scanned serially, and each modular multiply passes in turn
// through one shared 31x31 multiplier (product, Barrett quotient, quotient times modulus)
// and then a final fix-up step.
// Reset: rst_n clears the step counter to idle and drops out_valid; data registers are not reset.
module modular_exponentiation
    import modexp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BASE_W-1:0] base,
    input  logic [EXP_W-1:0]  exponent,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BASE_W-1:0] power
);

    localparam logic [31:0] P1 = 32'(MODULUS);
    localparam logic [31:0] P2 = 32'(MODULUS) << 1;
    localparam logic [31:0] E1 = 32'(EXP_MOD);
    localparam logic [31:0] E2 = 32'(EXP_MOD) << 1;

    logic [UPC_W-1:0]  upc_reg, upc_next;
    logic [BASE_W-1:0] rem_reg;
    logic [BASE_W-1:0] acc_reg;
    logic [BASE_W-1:0] sq_reg;
    logic [31:0]       x_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              out_valid_reg;
    logic [BASE_W-1:0] power_reg;

    ucode_t            cw;
    logic              start;
    logic              out_busy;
    logic              take;
    logic [BASE_W:0]   mul_a;
    logic [BASE_W:0]   mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [PROD_W-1:0] efold_x;
    logic [31:0]       fix_m1;
    logic [31:0]       fix_m2;
    logic [31:0]       fix_r;
    logic [BASE_W-1:0] fix_val;
    logic [BASE_W-1:0] base_red;

    assign cw        = ucode(upc_reg);
    assign in_stall  = (upc_reg != A_IDLE);
    assign start     = in_valid && !in_stall;
    assign out_busy  = out_valid_reg && out_stall;
    assign out_valid = out_valid_reg;
    assign power     = power_reg;

    always_comb
    begin
        unique case (cw.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_START: take = !start;
            C_E_ZERO:   take = (rem_reg == '0);
            C_E_EVEN:   take = !rem_reg[0];
            C_OUT_BUSY: take = out_busy;
            default:    take = 1'b1;
        endcase
        upc_next = take ? cw.target : upc_reg + 4'd1;
    end

    // shared multiplier: operand product, Barrett quotient estimate, quotient times modulus
    always_comb
    begin
        unique case (cw.op)
            OP_MULAB:
            begin
                mul_a = {1'b0, (cw.src_sq ? sq_reg : acc_reg)};
                mul_b = {1'b0, sq_reg};
            end
            OP_MULMU:
            begin
                mul_a = prod_reg[59:29];
                mul_b = cw.mod_e ? EXP_MU : BARRETT_MU;
            end
            default:
            begin
                mul_a = prod_reg[61:31];
                mul_b = {1'b0, (cw.mod_e ? EXP_MOD : MODULUS)};
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // top four exponent bits folded in as hi * 2^59 mod (p-1); sum stays below 2^60
    assign efold_x = PROD_W'(exponent[EXP_LO_W-1:0])
                   + PROD_W'(exp_fold(exponent[EXP_W-1:EXP_LO_W]));

    // Barrett remainder is below 3m: at most two subtractions
    always_comb
    begin
        fix_m1 = cw.mod_e ? E1 : P1;
        fix_m2 = cw.mod_e ? E2 : P2;
        fix_r  = x_reg - prod_reg[31:0];
        priority if (fix_r >= fix_m2)
            fix_val = BASE_W'(fix_r - fix_m2);
        else if (fix_r >= fix_m1)
            fix_val = BASE_W'(fix_r - fix_m1);
        else
            fix_val = fix_r[BASE_W-1:0];
    end

    assign base_red = (base >= MODULUS) ? base - MODULUS : base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= A_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg <= upc_next;
            if (cw.op == OP_OUT && !out_busy)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cw.op)
            OP_LOAD:
            begin
                if (start)
                begin
                    sq_reg   <= base_red;
                    prod_reg <= efold_x;
                    acc_reg  <= BASE_W'(1);
                end
            end
            OP_MULAB:
            begin
                prod_reg <= mul_p;
            end
            OP_MULMU:
            begin
                x_reg    <= prod_reg[31:0];
                prod_reg <= mul_p;
            end
            OP_MULP:
            begin
                prod_reg <= mul_p;
            end
            OP_FIX:
            begin
                if (cw.mod_e)
                    rem_reg <= fix_val;
                else
                begin
                    if (cw.dest_sq)
                        sq_reg <= fix_val;
                    else
                        acc_reg <= fix_val;
                    if (cw.shift_e)
                        rem_reg <= rem_reg >> 1;
                end
            end
            OP_OUT:
            begin
                if (!out_busy)
                    power_reg <= acc_reg;
            end
            default:
            begin
            end
        endcase
    end

endmodule
